// ===== hw/rtl/wsmd5_pkg.sv =====
// Package for the whitespace skeleton MD5 digest core.
// Holds the byte codes, MD5 round tables and queue entry type.
// No dependencies.
`default_nettype none
package wsmd5_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_PAD   = 8'h80;
    localparam logic [7:0] BLANKS_RESET = 8'd20;
    localparam logic [7:0] BREAKS_RESET = 8'd2;
    localparam logic       CFG_MIN_BLANKS = 1'b0;
    localparam logic       CFG_MIN_BREAKS = 1'b1;

    // Queue entry from the filter front to the hash back end.
    typedef struct packed {
        logic       fin;      // end of message marker
        logic       reject;   // message did not qualify (valid with fin)
        logic [7:0] data;     // kept byte (ignored with fin)
    } kept_t;

    function automatic logic [31:0] md_k(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0: k=32'hd76aa478; 6'd1: k=32'he8c7b756; 6'd2: k=32'h242070db; 6'd3: k=32'hc1bdceee;
            6'd4: k=32'hf57c0faf; 6'd5: k=32'h4787c62a; 6'd6: k=32'ha8304613; 6'd7: k=32'hfd469501;
            6'd8: k=32'h698098d8; 6'd9: k=32'h8b44f7af; 6'd10: k=32'hffff5bb1; 6'd11: k=32'h895cd7be;
            6'd12: k=32'h6b901122; 6'd13: k=32'hfd987193; 6'd14: k=32'ha679438e; 6'd15: k=32'h49b40821;
            6'd16: k=32'hf61e2562; 6'd17: k=32'hc040b340; 6'd18: k=32'h265e5a51; 6'd19: k=32'he9b6c7aa;
            6'd20: k=32'hd62f105d; 6'd21: k=32'h02441453; 6'd22: k=32'hd8a1e681; 6'd23: k=32'he7d3fbc8;
            6'd24: k=32'h21e1cde6; 6'd25: k=32'hc33707d6; 6'd26: k=32'hf4d50d87; 6'd27: k=32'h455a14ed;
            6'd28: k=32'ha9e3e905; 6'd29: k=32'hfcefa3f8; 6'd30: k=32'h676f02d9; 6'd31: k=32'h8d2a4c8a;
            6'd32: k=32'hfffa3942; 6'd33: k=32'h8771f681; 6'd34: k=32'h6d9d6122; 6'd35: k=32'hfde5380c;
            6'd36: k=32'ha4beea44; 6'd37: k=32'h4bdecfa9; 6'd38: k=32'hf6bb4b60; 6'd39: k=32'hbebfbc70;
            6'd40: k=32'h289b7ec6; 6'd41: k=32'heaa127fa; 6'd42: k=32'hd4ef3085; 6'd43: k=32'h04881d05;
            6'd44: k=32'hd9d4d039; 6'd45: k=32'he6db99e5; 6'd46: k=32'h1fa27cf8; 6'd47: k=32'hc4ac5665;
            6'd48: k=32'hf4292244; 6'd49: k=32'h432aff97; 6'd50: k=32'hab9423a7; 6'd51: k=32'hfc93a039;
            6'd52: k=32'h655b59c3; 6'd53: k=32'h8f0ccc92; 6'd54: k=32'hffeff47d; 6'd55: k=32'h85845dd1;
            6'd56: k=32'h6fa87e4f; 6'd57: k=32'hfe2ce6e0; 6'd58: k=32'ha3014314; 6'd59: k=32'h4e0811a1;
            6'd60: k=32'hf7537e82; 6'd61: k=32'hbd3af235; 6'd62: k=32'h2ad7d2bb; 6'd63: k=32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md_s(input logic [5:0] i);
        logic [4:0] s;
        unique case ({i[5:4], i[1:0]})
            4'd0: s=5'd7;  4'd1: s=5'd12; 4'd2: s=5'd17; 4'd3: s=5'd22;
            4'd4: s=5'd5;  4'd5: s=5'd9;  4'd6: s=5'd14; 4'd7: s=5'd20;
            4'd8: s=5'd4;  4'd9: s=5'd11; 4'd10: s=5'd16; 4'd11: s=5'd23;
            4'd12: s=5'd6; 4'd13: s=5'd10; 4'd14: s=5'd15; 4'd15: s=5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h57 + {4'h0, n});
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/whitespace_skeleton_md5_digest_core.sv =====
// Whitespace skeleton MD5 digest core: filter front, 4-entry queue, MD5 back end.
// Throughput: one byte per cycle at the front while the queue has room and no flush runs;
// after each 64 kept bytes the back end loads and compresses the block and takes no bytes.
// At the end of a message the front flushes its held bytes and the end marker; the back end
// pads and compresses once or twice, then gives 32 characters, one per cycle while m_ready holds.
// Reset: synchronous active low aresetn clears all control state; thresholds go to 20 and 2.
`default_nettype none
module whitespace_skeleton_md5_digest_core (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_msg_byte,
    input  wire logic       s_msg_end,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_hex_char,
    output logic            m_status,
    output logic            m_run_end
);
    logic [7:0] min_blanks_reg, min_breaks_reg;
    logic fq_valid, fq_ready, qb_valid, qb_ready;
    wsmd5_pkg::kept_t fq_data, qb_data;

    // Hold the qualification thresholds; the user must write them only while idle, the block does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_blanks_reg <= wsmd5_pkg::BLANKS_RESET;
            min_breaks_reg <= wsmd5_pkg::BREAKS_RESET;
        end else if (cfg_we) begin
            if (cfg_index == wsmd5_pkg::CFG_MIN_BLANKS) min_blanks_reg <= cfg_data;
            else min_breaks_reg <= cfg_data;
        end
    end

    // Front: drop visible bytes, squeeze whitespace, decide qualification.
    wsmd5_front u_front (
        .aclk, .aresetn,
        .min_blanks(min_blanks_reg), .min_line_breaks(min_breaks_reg),
        .in_valid(s_valid), .in_ready(s_ready), .in_byte(s_msg_byte), .in_end(s_msg_end),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
    );

    // Queue decouples the front from the round engine.
    wsmd5_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
    );

    // Back end: MD5 compression and hex transactions on the result channel.
    wsmd5_hash u_hash (
        .aclk, .aresetn,
        .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
        .out_valid(m_valid), .out_ready(m_ready), .out_char(m_hex_char),
        .out_status(m_status), .out_last(m_run_end)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/wsmd5_front.sv =====
// Filter front: classifies raw bytes, squeezes whitespace, counts blanks and CRs.
// Depends on wsmd5_pkg.
`default_nettype none
module wsmd5_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [7:0]        min_blanks,
    input  wire logic [7:0]        min_line_breaks,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_end,
    output logic                   q_valid,
    input  wire logic              q_ready,
    output wsmd5_pkg::kept_t       q_data
);
    // FSM: IDLE takes a byte; FLUSH_B/FLUSH_H drain the held bytes; FIN sends the marker.
    localparam logic [1:0] ST_IDLE = 2'd0, ST_FLB = 2'd1, ST_FLH = 2'd2, ST_FIN = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [7:0] blank_reg, blank_next, cr_reg, cr_next;
    logic [1:0] run_reg, run_next;
    logic [7:0] held_reg, held_next, bef_reg, bef_next;
    logic       hv_reg, hv_next, bv_reg, bv_next, rej_reg, rej_next;

    logic [7:0] c, bl_tmp, cr_tmp;
    logic       is_ws, vis, fire;
    logic [7:0] h1, b1;
    logic       hv1, bv1, keep;

    assign c     = in_byte;
    assign fire  = in_valid && in_ready;
    assign is_ws = (c == wsmd5_pkg::CH_SPACE) || (c >= 8'h09 && c <= 8'h0d);
    assign vis   = (c >= 8'h21) && (c <= 8'h7e);

    always_comb begin
        state_next = state_reg;
        blank_next = blank_reg; cr_next = cr_reg; run_next = run_reg;
        held_next = held_reg; bef_next = bef_reg; hv_next = hv_reg; bv_next = bv_reg;
        rej_next = rej_reg;
        in_ready = 1'b0; q_valid = 1'b0;
        q_data = '{fin: 1'b0, reject: 1'b0, data: bef_reg};
        bl_tmp = blank_reg; cr_tmp = cr_reg;
        h1 = held_reg; b1 = bef_reg; hv1 = hv_reg; bv1 = bv_reg; keep = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // a byte can always advance unless it pushes a held byte to a full queue
                if (c == wsmd5_pkg::CH_SPACE || c == wsmd5_pkg::CH_TAB ||
                    c == wsmd5_pkg::CH_LF || c == wsmd5_pkg::CH_CR) begin
                    if (blank_reg != 8'hff) bl_tmp = blank_reg + 8'd1;
                    if (c == wsmd5_pkg::CH_CR && cr_reg != 8'hff) cr_tmp = cr_reg + 8'd1;
                end
                if (!vis) begin
                    if (c == wsmd5_pkg::CH_LF && hv_reg && held_reg == wsmd5_pkg::CH_CR &&
                        run_reg == 2'd1) begin
                        h1 = bef_reg; hv1 = bv_reg; b1 = 8'h00; bv1 = 1'b0;
                    end
                    if (is_ws) keep = !hv1 || run_reg == 2'd0 || h1 != c;
                    else       keep = 1'b1;
                end
                q_valid = in_valid && keep && bv1;
                q_data  = '{fin: 1'b0, reject: 1'b0, data: b1};
                in_ready = !(keep && bv1) || q_ready;
                if (fire) begin
                    blank_next = bl_tmp; cr_next = cr_tmp;
                    if (vis) run_next = 2'd0;
                    else if (is_ws) begin
                        if (keep) run_next = 2'd1;
                        else if (run_reg != 2'd2) run_next = run_reg + 2'd1;
                    end
                    if (keep) begin
                        bef_next = h1; bv_next = hv1; held_next = c; hv_next = 1'b1;
                    end else begin
                        bef_next = b1; bv_next = bv1; held_next = h1; hv_next = hv1;
                    end
                    if (in_end) begin
                        rej_next = !(bl_tmp >= min_blanks || cr_tmp >= min_line_breaks);
                        state_next = ST_FLB;
                    end
                end
            end
            ST_FLB: begin
                q_valid = bv_reg && !rej_reg;
                q_data  = '{fin: 1'b0, reject: 1'b0, data: bef_reg};
                if (!q_valid || q_ready) state_next = ST_FLH;
            end
            ST_FLH: begin
                q_valid = hv_reg && !rej_reg;
                q_data  = '{fin: 1'b0, reject: 1'b0, data: held_reg};
                if (!q_valid || q_ready) state_next = ST_FIN;
            end
            ST_FIN: begin
                q_valid = 1'b1;
                q_data  = '{fin: 1'b1, reject: rej_reg, data: 8'h00};
                if (q_ready) begin
                    state_next = ST_IDLE;
                    blank_next = '0; cr_next = '0; run_next = '0;
                    held_next = '0; bef_next = '0; hv_next = 1'b0; bv_next = 1'b0;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            blank_reg <= '0; cr_reg <= '0; run_reg <= '0;
            held_reg <= '0; bef_reg <= '0; hv_reg <= 1'b0; bv_reg <= 1'b0; rej_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            blank_reg <= blank_next; cr_reg <= cr_next; run_reg <= run_next;
            held_reg <= held_next; bef_reg <= bef_next;
            hv_reg <= hv_next; bv_reg <= bv_next; rej_reg <= rej_next;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/wsmd5_queue.sv =====
// Four-entry queue between the filter front and the hash back end.
// Depends on wsmd5_pkg.
`default_nettype none
module wsmd5_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    input  wire wsmd5_pkg::kept_t  wr_data,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output wsmd5_pkg::kept_t       rd_data
);
    wsmd5_pkg::kept_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       wr_fire, rd_fire;

    assign wr_ready = cnt_reg != 3'd4;
    assign rd_valid = cnt_reg != 3'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr_fire) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr_fire) wp_reg <= wp_reg + 2'd1;
            if (rd_fire) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'b0, wr_fire} - {2'b0, rd_fire};
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/wsmd5_hash.sv =====
// Hash back end: block buffer, MD5 rounds one per cycle, padding, hex output.
// Depends on wsmd5_pkg.
`default_nettype none
module wsmd5_hash (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    output logic                   q_ready,
    input  wire wsmd5_pkg::kept_t  q_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_char,
    output logic                   out_status,
    output logic                   out_last
);
    localparam logic [2:0] ST_FILL = 3'd0, ST_LOAD = 3'd1, ST_ROUND = 3'd2,
                           ST_PAD = 3'd3, ST_OUT = 3'd4, ST_REJ = 3'd5;

    logic [2:0]  state_reg;
    logic        padding_reg, lenph_reg;   // in tail padding; length bytes phase
    logic [31:0] h_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [5:0]  rnd_reg;
    logic [63:0] total_reg, bits_reg;
    logic [4:0]  oidx_reg;
    logic [31:0] word_mem [16];
    logic [31:0] w_rd_reg;
    logic [3:0]  g_now, g_next;
    logic [31:0] f, t, rot, newb;
    logic [4:0]  sh;
    logic [7:0]  wbyte;
    logic        wen, q_fire;
    logic [5:0]  pos;
    logic [7:0]  dbyte;
    logic [31:0] dword;

    function automatic logic [3:0] gidx(input logic [5:0] i);
        logic [3:0] g;
        unique case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = 4'(5 * i[3:0] + 1);
            2'd2: g = 4'(3 * i[3:0] + 5);
            2'd3: g = 4'(7 * i[3:0]);
            default: g = 4'd0;
        endcase
        return g;
    endfunction

    assign pos    = total_reg[5:0];
    assign g_now  = gidx(rnd_reg);
    assign g_next = gidx(rnd_reg + 6'd1);
    assign q_fire = q_valid && q_ready;

    always_comb begin
        unique case (rnd_reg[5:4])
            2'd0: f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2: f = b_reg ^ c_reg ^ d_reg;
            2'd3: f = c_reg ^ (b_reg | ~d_reg);
            default: f = '0;
        endcase
        t    = f + a_reg + wsmd5_pkg::md_k(rnd_reg) + w_rd_reg;
        sh   = wsmd5_pkg::md_s(rnd_reg);
        rot  = (t << sh) | (t >> (6'd32 - {1'b0, sh}));
        newb = b_reg + rot;
    end

    assign q_ready = (state_reg == ST_FILL);

    // Byte to store this cycle: a kept byte, or padding / length bytes.
    always_comb begin
        wen = 1'b0; wbyte = 8'h00;
        if (state_reg == ST_FILL && q_fire && !q_data.fin) begin
            wen = 1'b1; wbyte = q_data.data;
        end else if (state_reg == ST_PAD) begin
            wen = 1'b1;
            if (lenph_reg) wbyte = bits_reg[8*pos[2:0] +: 8];
            else if (!padding_reg) wbyte = wsmd5_pkg::CH_PAD;
            else wbyte = 8'h00;
        end
    end

    assign dword = h_reg[oidx_reg[4:3]];
    assign dbyte = dword[8*oidx_reg[2:1] +: 8];
    assign out_valid  = (state_reg == ST_OUT) || (state_reg == ST_REJ);
    assign out_char   = (state_reg == ST_REJ) ? 8'h00 :
                        wsmd5_pkg::hex_ascii(oidx_reg[0] ? dbyte[3:0] : dbyte[7:4]);
    assign out_status = (state_reg == ST_REJ);
    assign out_last   = (state_reg == ST_REJ) || (oidx_reg == 5'd31);

    always_ff @(posedge aclk) begin
        if (wen) word_mem[pos[5:2]][8*pos[1:0] +: 8] <= wbyte;
        if (state_reg == ST_LOAD) w_rd_reg <= word_mem[g_now];
        else w_rd_reg <= word_mem[g_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FILL;
            padding_reg <= 1'b0; lenph_reg <= 1'b0;
            total_reg <= '0; bits_reg <= '0; rnd_reg <= '0; oidx_reg <= '0;
            h_reg[0] <= 32'h67452301; h_reg[1] <= 32'hefcdab89;
            h_reg[2] <= 32'h98badcfe; h_reg[3] <= 32'h10325476;
        end else begin
            unique case (state_reg)
                ST_FILL: begin
                    if (q_fire) begin
                        if (q_data.fin) begin
                            if (q_data.reject) state_reg <= ST_REJ;
                            else begin
                                bits_reg <= {total_reg[60:0], 3'b000};
                                state_reg <= ST_PAD;
                            end
                        end else begin
                            total_reg <= total_reg + 64'd1;
                            if (pos == 6'd63) state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_PAD: begin
                    total_reg <= total_reg + 64'd1;
                    padding_reg <= 1'b1;
                    if (pos == 6'd55 && !lenph_reg) lenph_reg <= 1'b1;
                    if (pos == 6'd63) state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    a_reg <= h_reg[0]; b_reg <= h_reg[1];
                    c_reg <= h_reg[2]; d_reg <= h_reg[3];
                    rnd_reg <= '0;
                    state_reg <= ST_ROUND;
                end
                ST_ROUND: begin
                    a_reg <= d_reg; d_reg <= c_reg; c_reg <= b_reg; b_reg <= newb;
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63) begin
                        h_reg[0] <= h_reg[0] + d_reg; h_reg[1] <= h_reg[1] + newb;
                        h_reg[2] <= h_reg[2] + b_reg; h_reg[3] <= h_reg[3] + c_reg;
                        if (lenph_reg) begin
                            state_reg <= ST_OUT; oidx_reg <= '0;
                        end else if (padding_reg) state_reg <= ST_PAD;
                        else state_reg <= ST_FILL;
                    end
                end
                ST_OUT: begin
                    if (out_ready) begin
                        oidx_reg <= oidx_reg + 5'd1;
                        if (oidx_reg == 5'd31) begin
                            state_reg <= ST_FILL;
                            padding_reg <= 1'b0; lenph_reg <= 1'b0; total_reg <= '0;
                            h_reg[0] <= 32'h67452301; h_reg[1] <= 32'hefcdab89;
                            h_reg[2] <= 32'h98badcfe; h_reg[3] <= 32'h10325476;
                        end
                    end
                end
                ST_REJ: begin
                    if (out_ready) begin
                        state_reg <= ST_FILL;
                        total_reg <= '0;
                        h_reg[0] <= 32'h67452301; h_reg[1] <= 32'hefcdab89;
                        h_reg[2] <= 32'h98badcfe; h_reg[3] <= 32'h10325476;
                    end
                end
                default: state_reg <= ST_FILL;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/wsmd5_checker.sv =====
// Port-level checker for the digest core, bound to the top level.
// Depends on whitespace_skeleton_md5_digest_core ports only.
`default_nettype none
module wsmd5_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_hex_char,
    input wire logic       m_status,
    input wire logic       m_run_end
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hex_char)) else $error("result dropped");
    a_rej: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_run_end && m_hex_char == 8'h00) else $error("bad reject");
    a_hex: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_status |-> (m_hex_char >= 8'h30 && m_hex_char <= 8'h39) ||
        (m_hex_char >= 8'h61 && m_hex_char <= 8'h66)) else $error("bad hex");
    a_after: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_run_end |=> m_valid && !m_status) else $error("gap");
endmodule

bind whitespace_skeleton_md5_digest_core wsmd5_checker u_chk (.*);
`default_nettype wire

// ===== verif/wsmd5_digest_checker.sv =====
// Checker for the whitespace skeleton MD5 digest core: watches the byte and
// hex channels, predicts every result and compares it. Depends on wsmd5_pkg.
`timescale 1ns / 1ps
module wsmd5_digest_checker (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       s_valid,
    input  wire logic       s_ready,
    input  wire logic [7:0] s_msg_byte,
    input  wire logic       s_msg_end,
    input  wire logic       m_valid,
    input  wire logic       m_ready,
    input  wire logic [7:0] m_hex_char,
    input  wire logic       m_status,
    input  wire logic       m_run_end,
    output int              fail_count,
    output int              pending,
    output int              results_seen
);

    typedef struct {
        logic [7:0] hex_char;
        logic       status;
        logic       run_end;
    } hex_result_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int ROUND_SHIFT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                        4, 11, 16, 23, 6, 10, 15, 21};

    logic [7:0]  min_blanks, min_breaks;
    logic [7:0]  blank_cnt, cr_cnt;
    logic [1:0]  run_len;
    logic [7:0]  last_kept, prior_kept;
    logic        last_ok, prior_ok;
    logic [31:0] chain [4];
    logic [7:0]  chunk [64];
    logic [63:0] kept_total;
    hex_result_t hex_q [$];

    function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic logic [7:0] nibble_char(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h61 + 8'(n) - 8'd10;
    endfunction

    task automatic new_message();
        blank_cnt = '0; cr_cnt = '0; run_len = '0;
        last_kept = '0; last_ok = 1'b0; prior_kept = '0; prior_ok = 1'b0;
        chain[0] = 32'h67452301; chain[1] = 32'hefcdab89;
        chain[2] = 32'h98badcfe; chain[3] = 32'h10325476;
        kept_total = '0;
    endtask

    task automatic compress_chunk();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, t;
        int g;
        for (int i = 0; i < 16; i++)
            w[i] = {chunk[4*i+3], chunk[4*i+2], chunk[4*i+1], chunk[4*i]};
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        for (int i = 0; i < 64; i++) begin
            if (i < 16) begin
                f = (b & c) | (~b & d); g = i;
            end else if (i < 32) begin
                f = (d & b) | (~d & c); g = (5 * i + 1) & 15;
            end else if (i < 48) begin
                f = b ^ c ^ d; g = (3 * i + 5) & 15;
            end else begin
                f = c ^ (b | ~d); g = (7 * i) & 15;
            end
            t = f + a + ROUND_K[i] + w[g];
            a = d; d = c; c = b;
            b = b + rotl(t, ROUND_SHIFT[((i >> 4) << 2) | (i & 3)]);
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endtask

    task automatic hash_byte(input logic [7:0] v);
        chunk[kept_total[5:0]] = v;
        kept_total++;
        if (kept_total[5:0] == 6'd0)
            compress_chunk();
    endtask

    task automatic keep(input logic [7:0] v);
        if (prior_ok)
            hash_byte(prior_kept);
        prior_kept = last_kept; prior_ok = last_ok;
        last_kept = v; last_ok = 1'b1;
    endtask

    task automatic absorb_byte(input logic [7:0] c, input logic fin);
        logic [63:0] bit_len;
        logic [7:0] dig;
        logic is_ws;
        hex_result_t r;
        is_ws = (c == wsmd5_pkg::CH_SPACE) ||
                (c >= wsmd5_pkg::CH_TAB && c <= wsmd5_pkg::CH_CR);
        if (c == wsmd5_pkg::CH_SPACE || c == wsmd5_pkg::CH_TAB ||
            c == wsmd5_pkg::CH_LF || c == wsmd5_pkg::CH_CR) begin
            if (blank_cnt != 8'hff) blank_cnt++;
            if (c == wsmd5_pkg::CH_CR && cr_cnt != 8'hff) cr_cnt++;
        end
        if (c >= 8'h21 && c <= 8'h7e) begin
            run_len = '0;
        end else begin
            // retract a lone CR when its LF arrives
            if (c == wsmd5_pkg::CH_LF && last_ok && last_kept == wsmd5_pkg::CH_CR &&
                run_len == 2'd1) begin
                last_kept = prior_kept; last_ok = prior_ok;
                prior_kept = '0; prior_ok = 1'b0;
            end
            if (is_ws) begin
                if (!last_ok || run_len == 2'd0 || last_kept != c) begin
                    keep(c);
                    run_len = 2'd1;
                end else if (run_len < 2'd2) begin
                    run_len++;
                end
            end else begin
                keep(c);
            end
        end
        if (!fin)
            return;
        if (!(blank_cnt >= min_blanks || cr_cnt >= min_breaks)) begin
            r.hex_char = '0; r.status = 1'b1; r.run_end = 1'b1;
            hex_q.push_back(r);
        end else begin
            if (prior_ok) hash_byte(prior_kept);
            if (last_ok) hash_byte(last_kept);
            bit_len = kept_total << 3;
            hash_byte(wsmd5_pkg::CH_PAD);
            while (kept_total[5:0] != 6'd56)
                hash_byte(8'h00);
            for (int i = 0; i < 8; i++)
                hash_byte(bit_len[8*i +: 8]);
            for (int k = 0; k < 32; k++) begin
                dig = chain[k >> 3][8 * ((k >> 1) & 3) +: 8];
                r.hex_char = nibble_char((k & 1) ? dig[3:0] : dig[7:4]);
                r.status = 1'b0;
                r.run_end = (k == 31);
                hex_q.push_back(r);
            end
        end
        new_message();
    endtask

    always @(posedge aclk) begin
        hex_result_t exp_r;
        if (!aresetn) begin
            min_blanks = wsmd5_pkg::BLANKS_RESET;
            min_breaks = wsmd5_pkg::BREAKS_RESET;
            new_message();
            hex_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == wsmd5_pkg::CFG_MIN_BLANKS) min_blanks = cfg_data;
                else if (cfg_index == wsmd5_pkg::CFG_MIN_BREAKS) min_breaks = cfg_data;
            end
            if (s_valid && s_ready)
                absorb_byte(s_msg_byte, s_msg_end);
            if (m_valid && m_ready) begin
                results_seen++;
                if (hex_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result hex=%h status=%b end=%b",
                             $time, m_hex_char, m_status, m_run_end);
                end else begin
                    exp_r = hex_q.pop_front();
                    if (m_hex_char !== exp_r.hex_char || m_status !== exp_r.status ||
                        m_run_end !== exp_r.run_end) begin
                        fail_count++;
                        $display("%0t: mismatch expected hex=%h status=%b end=%b, got hex=%h status=%b end=%b",
                                 $time, exp_r.hex_char, exp_r.status, exp_r.run_end,
                                 m_hex_char, m_status, m_run_end);
                    end
                end
            end
        end
        pending = hex_q.size();
    end

    initial begin
        fail_count = 0;
        pending = 0;
        results_seen = 0;
    end

endmodule

// ===== verif/tb_whitespace_skeleton_md5_digest_core.sv =====
// Top of the digest core testbench: clock, reset, message stimulus, register
// phases and the verdict. Depends on the core, wsmd5_pkg and wsmd5_digest_checker.
`timescale 1ns / 1ps
module tb_whitespace_skeleton_md5_digest_core;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 400;   // padding plus two compressions, with margin
    localparam int RANDOM_ITEMS = 460;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_index = wsmd5_pkg::CFG_MIN_BLANKS;
    logic [7:0] cfg_data = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_msg_byte = '0;
    logic       s_msg_end = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_hex_char;
    logic       m_status;
    logic       m_run_end;

    int fail_count, pending, results_seen;
    int cycle_cnt = 0;
    int items_sent = 0;
    int msgs_sent = 0;
    bit tx_burst = 1'b0;   // when set, send without gaps
    bit rx_burst = 1'b0;   // when set, take every result at once
    int rx_wait = 0;
    bit rx_took = 1'b0;

    whitespace_skeleton_md5_digest_core dut (.*);

    wsmd5_digest_checker checker_i (.*);

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Watchdog: end the run when the cycle budget is gone.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("whitespace_skeleton_md5_digest_core regression: fail");
            $finish;
        end
    end

    // Result side: note each transaction, then draw a fresh stall for the next.
    always @(posedge aclk)
        rx_took <= m_valid && m_ready;

    always @(negedge aclk) begin
        logic nxt;
        if (rx_took)
            rx_wait = rx_burst ? 0 : $urandom_range(0, 17);
        if (rx_wait > 0) begin
            rx_wait--;
            nxt = 1'b0;
        end else begin
            nxt = 1'b1;
        end
        m_ready <= nxt;
    end

    // Offer one byte; called and returning at a falling edge. Hold valid across
    // back-to-back transactions so it never toggles within one step.
    task automatic push_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_msg_byte <= b;
        s_msg_end <= fin;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
        if (fin) msgs_sent++;
    endtask

    // Write both thresholds once the block has drained.
    task automatic set_thresholds(input logic [7:0] blanks, input logic [7:0] breaks);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= wsmd5_pkg::CFG_MIN_BLANKS;
        cfg_data <= blanks;
        @(negedge aclk);
        cfg_index <= wsmd5_pkg::CFG_MIN_BREAKS;
        cfg_data <= breaks;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_string(input byte unsigned msg [], input logic close);
        foreach (msg[i])
            push_byte(msg[i], close && (i == msg.size() - 1));
    endtask

    // Layout-heavy byte mix: blanks, CR/LF, runs, controls, high bytes, text.
    function automatic logic [7:0] pick_byte(input logic [7:0] prev);
        case ($urandom_range(0, 11))
            0, 1:    return 8'($urandom_range(8'h21, 8'h7e));
            2:       return wsmd5_pkg::CH_SPACE;
            3:       return wsmd5_pkg::CH_TAB;
            4:       return wsmd5_pkg::CH_LF;
            5:       return wsmd5_pkg::CH_CR;
            6, 7:    return prev;          // grow a run
            8:       return 8'($urandom_range(8'h0b, 8'h0c));
            9:       return 8'($urandom_range(0, 31));
            10:      return 8'($urandom_range(8'h7f, 8'hff));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_random_message(input int len);
        logic [7:0] b, prev;
        prev = wsmd5_pkg::CH_SPACE;
        for (int i = 0; i < len; i++) begin
            b = pick_byte(prev);
            // split some CRs into CR LF pairs to hit the retraction
            if (b == wsmd5_pkg::CH_CR && i < len - 1 && $urandom_range(0, 1)) begin
                push_byte(wsmd5_pkg::CH_CR, 1'b0);
                i++;
                b = wsmd5_pkg::CH_LF;
            end
            push_byte(b, i == len - 1);
            prev = b;
        end
    endtask

    initial begin
        int len;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed, reset thresholds: a lone visible byte rejects, then
        // CR LF SPACE CR LF qualifies on the CR count.
        push_string('{8'h41}, 1'b1);
        push_string('{wsmd5_pkg::CH_CR, wsmd5_pkg::CH_LF, wsmd5_pkg::CH_SPACE,
                      wsmd5_pkg::CH_CR, wsmd5_pkg::CH_LF}, 1'b1);

        // Everything qualifies: empty kept stream, squeeze, visible breaking
        // a run, retraction after other bytes, field extremes.
        set_thresholds(8'd0, 8'd0);
        push_string('{8'h7e}, 1'b1);
        push_string('{wsmd5_pkg::CH_SPACE, wsmd5_pkg::CH_SPACE, wsmd5_pkg::CH_SPACE,
                      8'h21, wsmd5_pkg::CH_SPACE}, 1'b1);
        push_string('{8'h00, wsmd5_pkg::CH_TAB, wsmd5_pkg::CH_CR, wsmd5_pkg::CH_LF,
                      wsmd5_pkg::CH_CR, wsmd5_pkg::CH_CR, wsmd5_pkg::CH_LF}, 1'b1);
        push_string('{8'hff, 8'h12, 8'h14, 8'h7f, 8'h80}, 1'b1);

        // Nothing qualifies short of saturation.
        set_thresholds(8'd255, 8'd255);
        push_string('{wsmd5_pkg::CH_SPACE, wsmd5_pkg::CH_CR, 8'hff}, 1'b1);

        // Random messages over a sequence of threshold settings.
        while (items_sent < RANDOM_ITEMS) begin
            if (msgs_sent % 6 == 0) begin
                case ($urandom_range(0, 4))
                    0:       set_thresholds(8'd0, 8'd255);
                    1:       set_thresholds(8'd255, 8'd1);
                    2:       set_thresholds(wsmd5_pkg::BLANKS_RESET, wsmd5_pkg::BREAKS_RESET);
                    3:       set_thresholds(8'($urandom_range(1, 12)), 8'($urandom_range(1, 4)));
                    default: set_thresholds(8'($urandom), 8'($urandom));
                endcase
                tx_burst = ($urandom_range(0, 3) == 0);
                rx_burst = ($urandom_range(0, 3) == 0);
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 140)
                                               : $urandom_range(1, 24);
            push_random_message(len);
        end
        s_valid <= 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("covered %0d bytes in %0d messages, %0d results checked",
                 items_sent, msgs_sent, results_seen);
        $display("thresholds swept from zero to 255, with random sender and receiver stalls");
        if (fail_count == 0) begin
            $display("whitespace_skeleton_md5_digest_core regression: pass");
        end else begin
            $display("%0d failures", fail_count);
            $display("whitespace_skeleton_md5_digest_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== whitespace_skeleton_md5_digest_core.f =====
hw/rtl/wsmd5_pkg.sv
hw/rtl/wsmd5_front.sv
hw/rtl/wsmd5_queue.sv
hw/rtl/wsmd5_hash.sv
hw/rtl/whitespace_skeleton_md5_digest_core.sv
hw/rtl/wsmd5_checker.sv
verif/wsmd5_digest_checker.sv
verif/tb_whitespace_skeleton_md5_digest_core.sv
